// ===== hdl/coe_pkg.sv =====
// Package: shared types, opcodes and status codes for the constant operator evaluator.
package coe_pkg;

  localparam int unsigned DataWidth = 64;
  localparam int unsigned MuxWays   = 4;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [4:0] {
    OP_ADD   = 5'd0,  OP_SUB  = 5'd1,  OP_MUL  = 5'd2,  OP_DIV  = 5'd3,
    OP_EQ    = 5'd4,  OP_LT   = 5'd5,  OP_LE   = 5'd6,  OP_GT   = 5'd7,
    OP_GE    = 5'd8,  OP_SHL  = 5'd9,  OP_ASR  = 5'd10, OP_POW  = 5'd11,
    OP_MUX   = 5'd12, OP_MUXN = 5'd13, OP_PLUS = 5'd14, OP_NEG  = 5'd15,
    OP_NOT   = 5'd16, OP_LNOT = 5'd17, OP_RAND = 5'd18, OP_RNAND = 5'd19,
    OP_ROR   = 5'd20, OP_RNOR = 5'd21, OP_RXOR = 5'd22, OP_RXNOR = 5'd23
  } opcode_e;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_DIVZ   = 3'd1,
    ST_NEGEXP = 3'd2,
    ST_ZPZ    = 3'd3,
    ST_NOSEL  = 3'd4,
    ST_SHIFT  = 3'd5,
    ST_NOFOLD = 3'd6
  } status_e;

  // Work class chosen by the front end.
  typedef enum logic [1:0] {
    CLS_DONE = 2'd0,
    CLS_MUL  = 2'd1,
    CLS_DIV  = 2'd2,
    CLS_POW  = 2'd3
  } class_e;

  typedef struct packed {
    logic [4:0]  opcode;
    logic signed [63:0] operand_a;
    logic signed [63:0] operand_b;
    logic signed [63:0] operand_c;
    logic signed [63:0] operand_d;
    logic [2:0]  way_count;
    logic [3:0]  select_flags;
  } in_beat_t;

  typedef struct packed {
    logic signed [63:0] result_value;
    logic [2:0]         status;
  } out_beat_t;

  // Classified work item between front and back.
  typedef struct packed {
    class_e      cls;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] value;
    logic [2:0]  status;
  } work_t;

endpackage

// ===== hdl/coe_front.sv =====
// Front end: accept beats, fold the cheap operators, classify the rest.
module coe_front import coe_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_beat_t in_data_i,
  output logic     wr_valid_o,
  input  logic     wr_ready_i,
  output work_t    wr_data_o
);

  work_t       w_q, w_d;
  logic        valid_q;
  logic [63:0] a, b, c, d;
  logic [63:0] r;
  logic [2:0]  st;
  class_e      cls;
  logic [2:0]  ways;
  logic        found;

  assign a = in_data_i.operand_a;
  assign b = in_data_i.operand_b;
  assign c = in_data_i.operand_c;
  assign d = in_data_i.operand_d;

  always_comb begin
    r = '0;
    st = ST_OK;
    cls = CLS_DONE;
    found = 1'b0;
    ways = (in_data_i.way_count > 3'(MuxWays)) ? 3'(MuxWays) : in_data_i.way_count;
    case (in_data_i.opcode)
      OP_ADD:  r = a + b;
      OP_SUB:  r = a - b;
      OP_MUL:  cls = CLS_MUL;
      OP_DIV:  if (b == '0) st = ST_DIVZ; else cls = CLS_DIV;
      OP_EQ:   r = {63'd0, a == b};
      OP_LT:   r = {63'd0, $signed(a) < $signed(b)};
      OP_LE:   r = {63'd0, $signed(a) <= $signed(b)};
      OP_GT:   r = {63'd0, $signed(a) > $signed(b)};
      OP_GE:   r = {63'd0, $signed(a) >= $signed(b)};
      OP_SHL, OP_ASR: begin
        if (b[63] || b >= 64'(DataWidth)) st = ST_SHIFT;
        else if (in_data_i.opcode == OP_SHL) r = a << b[5:0];
        else r = $unsigned($signed(a) >>> b[5:0]);
      end
      OP_POW: begin
        if (b[63]) st = ST_NEGEXP;
        else if (a == '0 && b == '0) st = ST_ZPZ;
        else cls = CLS_POW;
      end
      OP_MUX:  r = (a != '0) ? b : c;
      OP_MUXN: begin
        st = ST_NOSEL;
        for (int i = 0; i < 4; i++) begin
          if (!found && 3'(i) < ways && in_data_i.select_flags[i]) begin
            found = 1'b1;
            st = ST_OK;
            case (i)
              0: r = a;
              1: r = b;
              2: r = c;
              default: r = d;
            endcase
          end
        end
      end
      OP_PLUS:  r = a;
      OP_NEG:   r = '0 - a;
      OP_NOT:   r = ~a;
      OP_LNOT, OP_RNOR: r = {63'd0, a == '0};
      OP_RAND:  r = {63'd0, &a};
      OP_RNAND: r = {63'd0, ~&a};
      OP_ROR:   r = {63'd0, |a};
      OP_RXOR:  r = {63'd0, ^a};
      OP_RXNOR: r = {63'd0, ~^a};
      default:  st = ST_NOFOLD;
    endcase
    w_d.cls = cls;
    w_d.a = a;
    w_d.b = b;
    w_d.value = (st == ST_OK) ? r : '0;
    w_d.status = st;
  end

  assign in_ready_o = !valid_q || wr_ready_i;
  assign wr_valid_o = valid_q;
  assign wr_data_o  = w_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      w_q <= w_d;
    end
  end

endmodule

// ===== hdl/coe_queue.sv =====
// Short queue between front and back.
module coe_queue import coe_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  wr_valid_i,
  output logic  wr_ready_o,
  input  work_t wr_data_i,
  output logic  rd_valid_o,
  input  logic  rd_ready_i,
  output work_t rd_data_o
);

  work_t      mem_q [QueueDepth];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign wr_ready_o = cnt_q != 2'(QueueDepth);
  assign rd_valid_o = cnt_q != '0;
  assign rd_data_o  = mem_q[rp_q];
  assign push = wr_valid_i && wr_ready_o;
  assign pop  = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= wr_data_i;
  end

endmodule

// ===== hdl/coe_back.sv =====
// Back end: shift-add multiply, restoring divide and square-and-multiply power.
module coe_back import coe_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      rd_valid_i,
  output logic      rd_ready_o,
  input  work_t     rd_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_data_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_DIV, S_PSQ, S_PACC, S_DONE
  } state_e;

  state_e      state_q;
  logic [63:0] x_q, y_q, acc_q, sq_q, e_q, rem_q;
  logic [6:0]  cnt_q;
  logic        neg_q, pmul_q;
  logic [2:0]  st_q;
  logic        ovalid_q;
  out_beat_t   odata_q;
  logic [64:0] trial;
  logic [63:0] ma, mb;
  logic        load_out;

  assign ma = rd_data_i.a[63] ? '0 - rd_data_i.a : rd_data_i.a;
  assign mb = rd_data_i.b[63] ? '0 - rd_data_i.b : rd_data_i.b;
  assign trial = {rem_q, x_q[63]} - {1'b0, y_q};

  // Load the output register once the previous result has left or is leaving.
  assign load_out = (state_q == S_DONE) && (!ovalid_q || out_ready_i);

  assign rd_ready_o  = state_q == S_IDLE;
  assign out_valid_o = ovalid_q;
  assign out_data_o  = odata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ovalid_q <= 1'b0;
      odata_q <= '0;
      x_q <= '0;
      y_q <= '0;
      acc_q <= '0;
      sq_q <= '0;
      e_q <= '0;
      rem_q <= '0;
      cnt_q <= '0;
      neg_q <= 1'b0;
      pmul_q <= 1'b0;
      st_q <= '0;
    end else begin
      if (load_out) ovalid_q <= 1'b1;
      else if (out_valid_o && out_ready_i) ovalid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (rd_valid_i) begin
          st_q <= rd_data_i.status;
          cnt_q <= '0;
          unique case (rd_data_i.cls)
            CLS_MUL: begin
              x_q <= rd_data_i.a; y_q <= rd_data_i.b; acc_q <= '0;
              state_q <= S_MUL;
            end
            CLS_DIV: begin
              x_q <= ma; y_q <= mb; rem_q <= '0; acc_q <= '0;
              neg_q <= rd_data_i.a[63] ^ rd_data_i.b[63];
              state_q <= S_DIV;
            end
            CLS_POW: begin
              sq_q <= rd_data_i.a; e_q <= rd_data_i.b; acc_q <= 64'd1;
              state_q <= S_PACC;
            end
            default: begin
              acc_q <= rd_data_i.value;
              state_q <= S_DONE;
            end
          endcase
        end
        // one multiplier bit per cycle
        S_MUL: begin
          if (y_q[0]) acc_q <= acc_q + x_q;
          x_q <= x_q << 1;
          y_q <= y_q >> 1;
          cnt_q <= cnt_q + 7'd1;
          if (cnt_q == 7'd63) state_q <= S_DONE;
        end
        // one quotient bit per cycle
        S_DIV: begin
          if (!trial[64]) begin
            rem_q <= trial[63:0];
            acc_q <= {acc_q[62:0], 1'b1};
          end else begin
            rem_q <= {rem_q[62:0], x_q[63]};
            acc_q <= {acc_q[62:0], 1'b0};
          end
          x_q <= x_q << 1;
          cnt_q <= cnt_q + 7'd1;
          if (cnt_q == 7'd63) begin
            state_q <= S_DONE;
            pmul_q <= 1'b1;
          end
        end
        // power: pick step; multiply sub-steps reuse S_MUL-style loop in S_PSQ
        S_PACC: begin
          if (e_q == '0) begin
            state_q <= S_DONE;
          end else begin
            pmul_q <= e_q[0];
            x_q <= e_q[0] ? acc_q : sq_q;
            y_q <= sq_q;
            rem_q <= '0;
            cnt_q <= '0;
            state_q <= S_PSQ;
          end
        end
        S_PSQ: begin
          if (cnt_q != 7'd63) begin
            if (y_q[0]) rem_q <= rem_q + x_q;
            x_q <= x_q << 1;
            y_q <= y_q >> 1;
            cnt_q <= cnt_q + 7'd1;
          end else if (pmul_q) begin
            acc_q <= y_q[0] ? rem_q + x_q : rem_q;
            pmul_q <= 1'b0;
            x_q <= sq_q; y_q <= sq_q; rem_q <= '0; cnt_q <= '0;
          end else begin
            sq_q <= y_q[0] ? rem_q + x_q : rem_q;
            e_q <= e_q >> 1;
            state_q <= S_PACC;
          end
        end
        S_DONE: if (load_out) begin
          odata_q.status <= st_q;
          odata_q.result_value <= (neg_q && pmul_q) ? '0 - acc_q : acc_q;
          neg_q <= 1'b0;
          pmul_q <= 1'b0;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/constant_operator_evaluator_core.sv =====
// Top level of the constant operator evaluator.
// Power runs two 64-step shift-add multiplies per set exponent bit and one per clear bit.
// The back end works on one item at a time; the front and queue absorb up to three beats.
// Reset: rst_ni clears all handshake and state registers asynchronously.
module constant_operator_evaluator_core import coe_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_data_o
);

  logic  wr_valid, wr_ready, rd_valid, rd_ready;
  work_t wr_data, rd_data;

  // Front: decode and fold the cheap operators.
  coe_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .wr_valid_o(wr_valid), .wr_ready_i(wr_ready), .wr_data_o(wr_data)
  );

  // Queue: decouple front and back stalls.
  coe_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(wr_valid), .wr_ready_o(wr_ready), .wr_data_i(wr_data),
    .rd_valid_o(rd_valid), .rd_ready_i(rd_ready), .rd_data_o(rd_data)
  );

  // Back: iterative arithmetic and the output register.
  coe_back u_back (
    .clk_i, .rst_ni,
    .rd_valid_i(rd_valid), .rd_ready_o(rd_ready), .rd_data_i(rd_data),
    .out_valid_o, .out_ready_i, .out_data_o
  );

  // Error beats always carry a zero value.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_OK |-> out_data_o.result_value == '0)
    else $error("nonzero value with error status");

  // A pending result stays valid while the output is stalled.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped");

endmodule
